[rtl/core/psfm_pkg.sv]
// Shared constants, codes and types for the pedal sensor fault monitor.
package psfm_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned STATUS_W    = 8;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned TICKS_W     = 8;
  localparam int unsigned COUNT_W     = 5;

  localparam logic [TICKS_W-1:0]  DISC_TICKS      = 8'd10;
  localparam logic [SAMPLE_W-1:0] FLOW_MIN        = 16'd100;
  localparam logic [COUNT_W-1:0]  BUS_ERROR_LIMIT = 5'd15;
  localparam logic [COUNT_W-1:0]  COUNT_MAX       = 5'd31;
  localparam logic [PCT_W-1:0]    PCT_TOL         = 7'd10;
  localparam logic [SAMPLE_W-1:0] STUCK_LO        = 16'h0000;
  localparam logic [SAMPLE_W-1:0] STUCK_HI        = 16'hFFFF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_A_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_A_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_B_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_B_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_LOW       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_HIGH      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STEER_LOW       = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_STEER_HIGH      = 3'd7;

  // Fault codes
  localparam logic [CODE_W-1:0] FAULT_NONE       = 4'd0;
  localparam logic [CODE_W-1:0] FAULT_RANGE_A    = 4'd1;
  localparam logic [CODE_W-1:0] FAULT_RANGE_B    = 4'd2;
  localparam logic [CODE_W-1:0] FAULT_RANGE_BRK  = 4'd3;
  localparam logic [CODE_W-1:0] FAULT_RANGE_STR  = 4'd4;
  localparam logic [CODE_W-1:0] FAULT_DISCREP    = 4'd5;
  localparam logic [CODE_W-1:0] FAULT_STUCK_A    = 4'd6;
  localparam logic [CODE_W-1:0] FAULT_STUCK_B    = 4'd7;
  localparam logic [CODE_W-1:0] FAULT_STUCK_BRK  = 4'd8;
  localparam logic [CODE_W-1:0] FAULT_STUCK_STR  = 4'd9;
  localparam logic [CODE_W-1:0] FAULT_LOW_FLOW   = 4'd10;
  localparam logic [CODE_W-1:0] FAULT_CAN_BIT    = 4'd11;
  localparam logic [CODE_W-1:0] FAULT_CAN_STUFF  = 4'd12;
  localparam logic [CODE_W-1:0] FAULT_CAN_CRC    = 4'd13;
  localparam logic [CODE_W-1:0] FAULT_CAN_FORM   = 4'd14;
  localparam logic [CODE_W-1:0] FAULT_CAN_ACK    = 4'd15;

  // Bit positions in the CAN status byte
  localparam int unsigned BUS_ACK_BIT   = 0;
  localparam int unsigned BUS_FORM_BIT  = 1;
  localparam int unsigned BUS_CRC_BIT   = 2;
  localparam int unsigned BUS_STUFF_BIT = 3;
  localparam int unsigned BUS_BIT_BIT   = 4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] throttle_a_raw;
    logic [SAMPLE_W-1:0] throttle_b_raw;
    logic [SAMPLE_W-1:0] brake_raw;
    logic [SAMPLE_W-1:0] steer_raw;
    logic [PCT_W-1:0]    throttle_a_pct;
    logic [PCT_W-1:0]    throttle_b_pct;
    logic [SAMPLE_W-1:0] flow_left;
    logic [SAMPLE_W-1:0] flow_right;
    logic [STATUS_W-1:0] bus_status;
  } sample_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] throttle_a_low;
    logic [CFG_DATA_W-1:0] throttle_a_high;
    logic [CFG_DATA_W-1:0] throttle_b_low;
    logic [CFG_DATA_W-1:0] throttle_b_high;
    logic [CFG_DATA_W-1:0] brake_low;
    logic [CFG_DATA_W-1:0] brake_high;
    logic [CFG_DATA_W-1:0] steer_low;
    logic [CFG_DATA_W-1:0] steer_high;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  fault;
    logic [TICKS_W-1:0] ticks;
    logic [COUNT_W-1:0] count;
  } state_t;

endpackage

[rtl/core/psfm_sample_if.sv]
// Request channel carrying one set of sensor samples per control tick.
interface psfm_sample_if;
  logic                           valid;
  logic                           ready;
  logic [psfm_pkg::SAMPLE_W-1:0]  throttle_a_raw;
  logic [psfm_pkg::SAMPLE_W-1:0]  throttle_b_raw;
  logic [psfm_pkg::SAMPLE_W-1:0]  brake_raw;
  logic [psfm_pkg::SAMPLE_W-1:0]  steer_raw;
  logic [psfm_pkg::PCT_W-1:0]     throttle_a_pct;
  logic [psfm_pkg::PCT_W-1:0]     throttle_b_pct;
  logic [psfm_pkg::SAMPLE_W-1:0]  flow_left;
  logic [psfm_pkg::SAMPLE_W-1:0]  flow_right;
  logic [psfm_pkg::STATUS_W-1:0]  bus_status;

  modport source (
    output valid, throttle_a_raw, throttle_b_raw, brake_raw, steer_raw,
           throttle_a_pct, throttle_b_pct, flow_left, flow_right, bus_status,
    input  ready
  );

  modport sink (
    input  valid, throttle_a_raw, throttle_b_raw, brake_raw, steer_raw,
           throttle_a_pct, throttle_b_pct, flow_left, flow_right, bus_status,
    output ready
  );
endinterface

[rtl/core/psfm_fault_if.sv]
// Result channel carrying the latched fault code of each control tick.
interface psfm_fault_if;
  logic                         valid;
  logic                         ready;
  logic [psfm_pkg::CODE_W-1:0]  fault_code;

  modport source (output valid, fault_code, input ready);
  modport sink   (input valid, fault_code, output ready);
endinterface

[rtl/core/pedal_sensor_fault_monitor_unit.sv]
// Top level of the pedal sensor fault monitor: input stage, checks and result register.
//
//   channel  direction  handshake      payload
//   sample   in         valid/ready    four raw samples, two percentages, two flows, CAN status
//   fault    out        valid/ready    fault_code
//   cfg      in         cfg_wen        cfg_index, cfg_data (range bounds)
//
// Each request passes through the input register and then the result register;
// the checks and counter updates sit between them: one request per cycle unless stalled.
// The latched code and counters advance as a request moves into the result register.
// rst is synchronous and clears the pipeline, the state and the bounds to their defaults.
// A stalled result holds; one further request still lands in the input register.
module pedal_sensor_fault_monitor_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [psfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [psfm_pkg::CFG_DATA_W-1:0]      cfg_data,
  psfm_sample_if.sink                          sample,
  psfm_fault_if.source                         fault
);

  psfm_pkg::cfg_t     cfg;
  psfm_pkg::sample_t  s1_data;
  logic               s1_valid;
  logic               out_valid;
  logic [psfm_pkg::CODE_W-1:0] out_code;
  psfm_pkg::state_t   state;
  psfm_pkg::state_t   state_next;
  logic               out_free;
  logic               advance;

  assign out_free     = !out_valid || fault.ready;
  assign advance      = s1_valid && out_free;
  assign sample.ready = !s1_valid || advance;
  assign fault.valid      = out_valid;
  assign fault.fault_code = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_a_low  <= '0;
      cfg.throttle_a_high <= '1;
      cfg.throttle_b_low  <= '0;
      cfg.throttle_b_high <= '1;
      cfg.brake_low       <= '0;
      cfg.brake_high      <= '1;
      cfg.steer_low       <= '0;
      cfg.steer_high      <= '1;
    end else if (cfg_wen) begin
      case (cfg_index)
        psfm_pkg::REG_THROTTLE_A_LOW:  cfg.throttle_a_low  <= cfg_data;
        psfm_pkg::REG_THROTTLE_A_HIGH: cfg.throttle_a_high <= cfg_data;
        psfm_pkg::REG_THROTTLE_B_LOW:  cfg.throttle_b_low  <= cfg_data;
        psfm_pkg::REG_THROTTLE_B_HIGH: cfg.throttle_b_high <= cfg_data;
        psfm_pkg::REG_BRAKE_LOW:       cfg.brake_low       <= cfg_data;
        psfm_pkg::REG_BRAKE_HIGH:      cfg.brake_high      <= cfg_data;
        psfm_pkg::REG_STEER_LOW:       cfg.steer_low       <= cfg_data;
        psfm_pkg::REG_STEER_HIGH:      cfg.steer_high      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1_data.throttle_a_raw <= sample.throttle_a_raw;
      s1_data.throttle_b_raw <= sample.throttle_b_raw;
      s1_data.brake_raw      <= sample.brake_raw;
      s1_data.steer_raw      <= sample.steer_raw;
      s1_data.throttle_a_pct <= sample.throttle_a_pct;
      s1_data.throttle_b_pct <= sample.throttle_b_pct;
      s1_data.flow_left      <= sample.flow_left;
      s1_data.flow_right     <= sample.flow_right;
      s1_data.bus_status     <= sample.bus_status;
    end
  end

  psfm_check u_check (
    .smp     (s1_data),
    .cfg     (cfg),
    .st      (state),
    .st_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_code <= state_next.fault;
    end
  end

`ifndef ASSERT_OFF
  a_fault_sticks: assert property (@(posedge clk) disable iff (rst)
    state.fault != psfm_pkg::FAULT_NONE |=> state.fault != psfm_pkg::FAULT_NONE)
    else $error("latched fault code returned to none");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> state.count >= $past(state.count))
    else $error("CAN error count decreased");

  a_ticks_bounded: assert property (@(posedge clk) disable iff (rst)
    state.ticks <= psfm_pkg::DISC_TICKS + 8'd1)
    else $error("mismatch tick counter passed its ceiling");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_code == state.fault)
    else $error("result register disagrees with latched fault");
`endif

endmodule

[rtl/core/psfm_check.sv]
// Plausibility checks for one sample set: next latched code and counters.
module psfm_check (
  input  psfm_pkg::sample_t smp,
  input  psfm_pkg::cfg_t    cfg,
  input  psfm_pkg::state_t  st,
  output psfm_pkg::state_t  st_next
);

  logic                           mismatch;
  logic [psfm_pkg::PCT_W:0]       pct_a;
  logic [psfm_pkg::PCT_W:0]       pct_b;
  logic [psfm_pkg::PCT_W:0]       tol;
  logic [psfm_pkg::CODE_W-1:0]    can_code;
  logic [psfm_pkg::TICKS_W-1:0]   ticks_next;
  logic [psfm_pkg::COUNT_W-1:0]   count_next;
  logic [psfm_pkg::CODE_W-1:0]    code;

  always_comb begin
    pct_a = {1'b0, smp.throttle_a_pct};
    pct_b = {1'b0, smp.throttle_b_pct};
    tol   = {1'b0, psfm_pkg::PCT_TOL};
    mismatch = (pct_a > pct_b + tol) || (pct_b > pct_a + tol);

    if (mismatch) begin
      if (st.ticks <= psfm_pkg::DISC_TICKS) begin
        ticks_next = st.ticks + 8'd1;
      end else begin
        ticks_next = st.ticks;
      end
    end else begin
      ticks_next = '0;
    end

    // Later assignments win, so the ack error has the highest priority.
    can_code = psfm_pkg::FAULT_NONE;
    if (smp.bus_status[psfm_pkg::BUS_BIT_BIT])   can_code = psfm_pkg::FAULT_CAN_BIT;
    if (smp.bus_status[psfm_pkg::BUS_STUFF_BIT]) can_code = psfm_pkg::FAULT_CAN_STUFF;
    if (smp.bus_status[psfm_pkg::BUS_CRC_BIT])   can_code = psfm_pkg::FAULT_CAN_CRC;
    if (smp.bus_status[psfm_pkg::BUS_FORM_BIT])  can_code = psfm_pkg::FAULT_CAN_FORM;
    if (smp.bus_status[psfm_pkg::BUS_ACK_BIT])   can_code = psfm_pkg::FAULT_CAN_ACK;

    count_next = st.count;
    if (can_code != psfm_pkg::FAULT_NONE && st.count < psfm_pkg::COUNT_MAX) begin
      count_next = st.count + 5'd1;
    end

    // Checks run in a fixed order; a later failure overwrites the code.
    code = st.fault;
    if (smp.throttle_a_raw < cfg.throttle_a_low || smp.throttle_a_raw > cfg.throttle_a_high)
      code = psfm_pkg::FAULT_RANGE_A;
    if (smp.throttle_b_raw < cfg.throttle_b_low || smp.throttle_b_raw > cfg.throttle_b_high)
      code = psfm_pkg::FAULT_RANGE_B;
    if (smp.brake_raw < cfg.brake_low || smp.brake_raw > cfg.brake_high)
      code = psfm_pkg::FAULT_RANGE_BRK;
    if (smp.steer_raw < cfg.steer_low || smp.steer_raw > cfg.steer_high)
      code = psfm_pkg::FAULT_RANGE_STR;
    if (ticks_next >= psfm_pkg::DISC_TICKS)
      code = psfm_pkg::FAULT_DISCREP;
    if (smp.throttle_a_raw == psfm_pkg::STUCK_LO || smp.throttle_a_raw == psfm_pkg::STUCK_HI)
      code = psfm_pkg::FAULT_STUCK_A;
    if (smp.throttle_b_raw == psfm_pkg::STUCK_LO || smp.throttle_b_raw == psfm_pkg::STUCK_HI)
      code = psfm_pkg::FAULT_STUCK_B;
    if (smp.brake_raw == psfm_pkg::STUCK_LO || smp.brake_raw == psfm_pkg::STUCK_HI)
      code = psfm_pkg::FAULT_STUCK_BRK;
    if (smp.steer_raw == psfm_pkg::STUCK_LO || smp.steer_raw == psfm_pkg::STUCK_HI)
      code = psfm_pkg::FAULT_STUCK_STR;
    if (smp.flow_left < psfm_pkg::FLOW_MIN || smp.flow_right < psfm_pkg::FLOW_MIN)
      code = psfm_pkg::FAULT_LOW_FLOW;
    if (can_code != psfm_pkg::FAULT_NONE && count_next > psfm_pkg::BUS_ERROR_LIMIT)
      code = can_code;

    st_next.fault = code;
    st_next.ticks = ticks_next;
    st_next.count = count_next;
  end

endmodule
